// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL of the position feedback filter.
// Needs clk and rst in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define APFF_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("invariant violated");

// Antecedent implies consequent in the same cycle.
`define APFF_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication violated");

`endif

// ===== hdl/apff_pkg.sv =====
// Package for the actuator position feedback filter: widths, register
// indexes and arithmetic constants. No dependencies.
`default_nettype none

package apff_pkg;

  // Channel set and sample format
  localparam int NUM_CH    = 3;
  localparam int ADC_BITS  = 10;
  localparam int CH_W      = 2;
  localparam int CH_IDX_W  = $clog2(NUM_CH);
  localparam int ES_IDX_W  = $clog2(2 * NUM_CH);

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ALPHA    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RAW_MIN         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RAW_MAX         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STROKE_LENGTH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_USED    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_PRESENT = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_ENDSTOP_PRESENT = 3'd7;

  // Register widths
  localparam int COUNT_W  = 8;
  localparam int ALPHA_W  = 17;
  localparam int STROKE_W = 16;

  // Datapath widths
  localparam int SUM_W    = 18;   // per-channel sample sum
  localparam int FV_W     = 26;   // filter state, unsigned Q10.16
  localparam int FRAC_W   = 16;
  localparam int PROD_W   = 43;   // (1-alpha) * filter state
  localparam int DIV_W    = 26;   // widest dividend (num * stroke)
  localparam int POS_MUL_STEPS = ADC_BITS;
  localparam int CNT_W    = $clog2(DIV_W + 1);

  localparam logic [ALPHA_W-1:0] ALPHA_ONE  = 17'h10000;
  localparam int                 ROUND_HALF = 32768;
  localparam logic [ADC_BITS-1:0] ADC_MAX   = {ADC_BITS{1'b1}};

endpackage

`default_nettype wire

// ===== hdl/actuator_position_feedback_filter_unit.sv =====
// Top level of the actuator position feedback filter: per-channel sample
// averaging, EMA filter and position scaling. Uses apff_pkg and assert_macros.svh.
//
// One sample is taken per transfer on the input channel; the block works on one
// sample at a time. A sample that only adds to a batch leaves the sequencer idle.
// An unused or invalid channel, or one without a sensor, goes straight to the
// output register with zero readings. A sample that completes the first batch of
// its channel after reset seeds that channel's filter with the mean. Any other
// completed batch runs these steps before the next transfer is taken: the mean
// (bit-serial restoring divider, one quotient bit a cycle over 18 bits), the
// filter update (shift-add, one bit of alpha a cycle), rounding and range setup,
// the stroke product and the position division over 26 bits, which reuses the
// same divider, then the load of the output register. With an invalid range the
// stroke product and division are skipped. The result register holds a finished
// reading while the next sample is accepted; a new reading waits as long as that
// register stays stalled.
// Reset is synchronous, active high.
`default_nettype none

`include "assert_macros.svh"

module actuator_position_feedback_filter_unit (
  input  logic                            clk,
  input  logic                            rst,
  // configuration writes
  input  logic                            cfg_write,
  input  logic [apff_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [apff_pkg::CFG_DATA_W-1:0] cfg_data,
  // sample input
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [apff_pkg::CH_W-1:0]       channel,
  input  logic [apff_pkg::ADC_BITS-1:0]   adc_sample,
  input  logic                            inner_switch_level,
  input  logic                            outer_switch_level,
  // reading output
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [apff_pkg::CH_W-1:0]       result_channel,
  output logic [apff_pkg::ADC_BITS-1:0]   raw_average,
  output logic [apff_pkg::ADC_BITS-1:0]   filtered_value,
  output logic [apff_pkg::STROKE_W-1:0]   position,
  output logic                            at_inner_end,
  output logic                            at_outer_end
);
  import apff_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MDIV = 3'd1;
  localparam logic [2:0] S_FMUL = 3'd2;
  localparam logic [2:0] S_FPOS = 3'd3;
  localparam logic [2:0] S_PSET = 3'd4;
  localparam logic [2:0] S_PMUL = 3'd5;
  localparam logic [2:0] S_PDIV = 3'd6;
  localparam logic [2:0] S_EMIT = 3'd7;

  // Configuration registers
  logic [COUNT_W-1:0]    sample_count;
  logic [ALPHA_W-1:0]    filter_alpha;
  logic [ADC_BITS-1:0]   raw_min;
  logic [ADC_BITS-1:0]   raw_max;
  logic [STROKE_W-1:0]   stroke_length;
  logic [NUM_CH-1:0]     channel_used_mask;
  logic [NUM_CH-1:0]     feedback_present_mask;
  logic [2*NUM_CH-1:0]   endstop_present_mask;

  // Per-channel state
  logic [SUM_W-1:0]      sample_sum    [NUM_CH];
  logic [COUNT_W-1:0]    samples_taken [NUM_CH];
  logic [FV_W-1:0]       filter_value  [NUM_CH];
  logic [NUM_CH-1:0]     filter_seeded;

  // Sequencer
  logic [2:0]            state;
  logic [CNT_W-1:0]      cnt;
  logic [CH_IDX_W-1:0]   cur_idx;

  // Result staging
  logic [CH_W-1:0]       r_ch;
  logic [ADC_BITS-1:0]   r_avg;
  logic [ADC_BITS-1:0]   r_filt;
  logic [STROKE_W-1:0]   r_pos;
  logic                  r_inner;
  logic                  r_outer;
  logic [FV_W-1:0]       fv_cur;

  // Serial divider: remainder, dividend/quotient shift register, divisor
  logic [ADC_BITS-1:0]   div_rem;
  logic [DIV_W-1:0]      div_q;
  logic [ADC_BITS-1:0]   div_d;

  // Serial multipliers: multiplier bits shift right, multiplicands shift left
  logic [ALPHA_W-1:0]    mplier_p;
  logic [ALPHA_W-1:0]    mplier_m;
  logic [PROD_W-1:0]     mcand_p;
  logic [FV_W-1:0]       mcand_m;
  logic [PROD_W-1:0]     acc_p;
  logic [FV_W-1:0]       acc_m;

  // Input decode
  logic                  in_xfer;
  logic                  ch_ok;
  logic [CH_IDX_W-1:0]   ch_idx;
  logic [ES_IDX_W-1:0]   outer_idx;
  logic                  ch_used;
  logic                  ch_fb;
  logic                  inner_hit;
  logic                  outer_hit;
  logic [SUM_W-1:0]      new_sum;
  logic [COUNT_W-1:0]    new_taken;
  logic [COUNT_W-1:0]    n_target;

  // Datapath terms
  logic [ADC_BITS:0]     div_shift;
  logic [ADC_BITS+1:0]   div_trial;
  logic                  div_borrow;
  logic [SUM_W-1:0]      quot_mean;
  logic [ADC_BITS-1:0]   mean;
  logic [ALPHA_W-1:0]    alpha_sat;
  logic [PROD_W-1:0]     rnd_p;
  logic [FV_W-1:0]       fv_new;
  logic [FV_W:0]         rnd_f;
  logic [ADC_BITS-1:0]   range_w;
  logic [ADC_BITS-1:0]   num_w;
  logic                  out_free;

  assign in_stall = (state != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Channel and switch decode
  always_comb begin
    ch_ok     = (channel < CH_W'(NUM_CH));
    ch_idx    = channel[CH_IDX_W-1:0];
    outer_idx = ES_IDX_W'(ch_idx) + ES_IDX_W'(NUM_CH);
    ch_used   = ch_ok && channel_used_mask[ch_idx];
    ch_fb     = ch_used && feedback_present_mask[ch_idx];
    inner_hit = ch_used && endstop_present_mask[ES_IDX_W'(ch_idx)] && !inner_switch_level;
    outer_hit = ch_used && endstop_present_mask[outer_idx] && !outer_switch_level;
    new_sum   = sample_sum[ch_idx] + SUM_W'(adc_sample);
    new_taken = samples_taken[ch_idx] + COUNT_W'(1);
    n_target  = (sample_count == '0) ? COUNT_W'(1) : sample_count;
  end

  // Divider step and result terms
  always_comb begin
    div_shift  = {div_rem, div_q[DIV_W-1]};
    div_trial  = {1'b0, div_shift} - {2'b00, div_d};
    div_borrow = div_trial[ADC_BITS+1];

    quot_mean  = div_q[SUM_W-1:0];
    mean       = (quot_mean > SUM_W'(ADC_MAX)) ? ADC_MAX : quot_mean[ADC_BITS-1:0];
    alpha_sat  = (filter_alpha > ALPHA_ONE) ? ALPHA_ONE : filter_alpha;

    rnd_p      = acc_p + PROD_W'(ROUND_HALF);
    fv_new     = acc_m + rnd_p[FRAC_W+FV_W-1:FRAC_W];
    rnd_f      = {1'b0, fv_cur} + (FV_W+1)'(ROUND_HALF);

    range_w    = raw_max - raw_min;
    num_w      = (r_filt > raw_min) ? (r_filt - raw_min) : '0;
    if (num_w > range_w) begin
      num_w = range_w;
    end
  end

  // Configuration, state and sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count          <= COUNT_W'(1);
      filter_alpha          <= ALPHA_W'(13107);
      raw_min               <= '0;
      raw_max               <= ADC_MAX;
      stroke_length         <= STROKE_W'(1600);
      channel_used_mask     <= '0;
      feedback_present_mask <= '0;
      endstop_present_mask  <= '0;
      for (int i = 0; i < NUM_CH; i++) begin
        sample_sum[i]    <= '0;
        samples_taken[i] <= '0;
        filter_value[i]  <= '0;
      end
      filter_seeded <= '0;
      state         <= S_IDLE;
      cnt           <= '0;
      out_valid     <= 1'b0;
    end else begin
      // register writes
      if (cfg_write) begin
        case (cfg_index)
          CFG_SAMPLE_COUNT:     sample_count          <= cfg_data[COUNT_W-1:0];
          CFG_FILTER_ALPHA:     filter_alpha          <= cfg_data[ALPHA_W-1:0];
          CFG_RAW_MIN:          raw_min               <= cfg_data[ADC_BITS-1:0];
          CFG_RAW_MAX:          raw_max               <= cfg_data[ADC_BITS-1:0];
          CFG_STROKE_LENGTH:    stroke_length         <= cfg_data[STROKE_W-1:0];
          CFG_CHANNEL_USED:     channel_used_mask     <= cfg_data[NUM_CH-1:0];
          CFG_FEEDBACK_PRESENT: feedback_present_mask <= cfg_data[NUM_CH-1:0];
          CFG_ENDSTOP_PRESENT:  endstop_present_mask  <= cfg_data[2*NUM_CH-1:0];
          default: ;
        endcase
      end

      // output register drains on transfer unless a new reading loads it
      if (out_valid && !out_stall && state != S_EMIT) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            cur_idx <= ch_idx;
            r_ch    <= channel;
            r_inner <= inner_hit;
            r_outer <= outer_hit;
            r_avg   <= '0;
            r_filt  <= '0;
            r_pos   <= '0;
            if (!ch_fb) begin
              state <= S_EMIT;
            end else if (new_taken < n_target) begin
              sample_sum[ch_idx]    <= new_sum;
              samples_taken[ch_idx] <= new_taken;
            end else begin
              // batch complete: mean = sum / taken
              sample_sum[ch_idx]    <= '0;
              samples_taken[ch_idx] <= '0;
              div_rem <= '0;
              div_q   <= {new_sum, (DIV_W-SUM_W)'(0)};
              div_d   <= ADC_BITS'(new_taken);
              cnt     <= CNT_W'(SUM_W);
              state   <= S_MDIV;
            end
          end
        end

        S_MDIV: begin
          if (cnt != '0) begin
            div_rem <= div_borrow ? div_shift[ADC_BITS-1:0] : div_trial[ADC_BITS-1:0];
            div_q   <= {div_q[DIV_W-2:0], !div_borrow};
            cnt     <= cnt - CNT_W'(1);
          end else if (!filter_seeded[cur_idx]) begin
            filter_value[cur_idx]  <= {mean, FRAC_W'(0)};
            filter_seeded[cur_idx] <= 1'b1;
            state <= S_IDLE;
          end else begin
            // alpha*mean and (1-alpha)*old, one multiplier bit a cycle
            r_avg    <= mean;
            mplier_m <= alpha_sat;
            mplier_p <= ALPHA_ONE - alpha_sat;
            mcand_m  <= FV_W'(mean);
            mcand_p  <= PROD_W'(filter_value[cur_idx]);
            acc_m    <= '0;
            acc_p    <= '0;
            cnt      <= CNT_W'(ALPHA_W);
            state    <= S_FMUL;
          end
        end

        S_FMUL: begin
          if (cnt != '0) begin
            if (mplier_p[0]) acc_p <= acc_p + mcand_p;
            if (mplier_m[0]) acc_m <= acc_m + mcand_m;
            mplier_p <= mplier_p >> 1;
            mplier_m <= mplier_m >> 1;
            mcand_p  <= mcand_p << 1;
            mcand_m  <= mcand_m << 1;
            cnt      <= cnt - CNT_W'(1);
          end else begin
            filter_value[cur_idx] <= fv_new;
            fv_cur <= fv_new;
            state  <= S_FPOS;
          end
        end

        // round half up and saturate to the ADC range
        S_FPOS: begin
          r_filt <= rnd_f[FV_W] ? ADC_MAX : rnd_f[FV_W-1:FRAC_W];
          state  <= S_PSET;
        end

        S_PSET: begin
          if (raw_max > raw_min) begin
            div_d    <= range_w;
            mplier_p <= ALPHA_W'(num_w);
            mcand_p  <= PROD_W'(stroke_length);
            acc_p    <= '0;
            cnt      <= CNT_W'(POS_MUL_STEPS);
            state    <= S_PMUL;
          end else begin
            state <= S_EMIT;
          end
        end

        S_PMUL: begin
          if (cnt != '0) begin
            if (mplier_p[0]) acc_p <= acc_p + mcand_p;
            mplier_p <= mplier_p >> 1;
            mcand_p  <= mcand_p << 1;
            cnt      <= cnt - CNT_W'(1);
          end else begin
            div_rem <= '0;
            div_q   <= acc_p[DIV_W-1:0];
            cnt     <= CNT_W'(DIV_W);
            state   <= S_PDIV;
          end
        end

        S_PDIV: begin
          if (cnt != '0) begin
            div_rem <= div_borrow ? div_shift[ADC_BITS-1:0] : div_trial[ADC_BITS-1:0];
            div_q   <= {div_q[DIV_W-2:0], !div_borrow};
            cnt     <= cnt - CNT_W'(1);
          end else begin
            r_pos <= div_q[STROKE_W-1:0];
            state <= S_EMIT;
          end
        end

        S_EMIT: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            result_channel <= r_ch;
            raw_average    <= r_avg;
            filtered_value <= r_filt;
            position       <= r_pos;
            at_inner_end   <= r_inner;
            at_outer_end   <= r_outer;
            state          <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // Divisor is never zero while the divider runs
  `APFF_ASSERT_IMPLIES(a_div_nonzero, (state == S_MDIV || state == S_PDIV), div_d != '0)
  // Filter update only runs on a seeded channel
  `APFF_ASSERT_IMPLIES(a_fmul_seeded, state == S_FMUL, filter_seeded[cur_idx])
  // Position quotient fits the stroke width
  `APFF_ASSERT_IMPLIES(a_pos_fits, (state == S_PDIV && cnt == '0),
                       div_q[DIV_W-1:STROKE_W] == '0)

endmodule

`default_nettype wire
